// ===== src/fat16_chain_sector_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// fat16 chain sector generator assertion macros
// Assertion helpers shared by the RTL, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FAT16_CHAIN_SECTOR_GENERATOR_UNIT_DEFINES_SVH
`define FAT16_CHAIN_SECTOR_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define FCSG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// same-cycle implication
`define FCSG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define FCSG_ASSERT(lbl, clk, rstn, prop, msg)
`define FCSG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg
// Widths, register indexes and reset values of the FAT16 sector generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsg_pkg;

  // field widths
  localparam int unsigned SECTOR_W    = 9;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned WORD_IDX_W  = 6;
  localparam int unsigned ENTRY_W     = 16;
  localparam int unsigned ENTRY_IDX_W = 8;
  // largest cluster number plus one: 2 + 16 * 65535 fits in 20 bits
  localparam int unsigned CLUSTER_W   = 20;

  // file slots
  localparam int unsigned MAX_FILE_SLOTS     = 16;
  localparam int unsigned FILE_SLOTS_DEFAULT = 16;
  localparam int unsigned SLOTS_PER_REG      = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_FAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILES_0_3       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILES_4_7       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILES_8_11      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILES_12_15     = 3'd4;

  // register reset values
  localparam logic [SECTOR_W-1:0]   SPF_RESET       = 9'd129;
  localparam logic [CFG_DATA_W-1:0] FILES_0_3_RESET   = 64'd63050532222205953;
  localparam logic [CFG_DATA_W-1:0] FILES_4_7_RESET   = 64'd576469548396511487;
  localparam logic [CFG_DATA_W-1:0] FILES_8_11_RESET  = 64'd576469548530665472;
  localparam logic [CFG_DATA_W-1:0] FILES_12_15_RESET = 64'd134219776;

  // FAT16 entry codes
  localparam logic [ENTRY_W-1:0]   MEDIA_ENTRY     = 16'hFFF8;
  localparam logic [ENTRY_W-1:0]   END_OF_CHAIN    = 16'hFFFF;
  localparam logic [ENTRY_W-1:0]   FREE_ENTRY      = 16'h0000;
  localparam logic [CLUSTER_W-1:0] FILE_AREA_BASE  = 20'd2;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

// ===== src/fat16_chain_sector_generator_unit.sv =====
// ----------------------------------------------------------------------------
// fat16_chain_sector_generator_unit: FAT16 allocation table sector generator
// A sector request is taken only while idle, after the previous sector's last word is generated.
// Generation runs one entry per cycle through the single end-of-file compare unit, four per word;
// the last entry of each word waits while the output register is not free.
// Reset: control and configuration registers take their reset values at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat16_chain_sector_generator_unit_defines.svh"

module fat16_chain_sector_generator_unit #(
  parameter int unsigned FILE_SLOTS = fcsg_pkg::FILE_SLOTS_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write channel
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [fcsg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fcsg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // sector request channel
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [fcsg_pkg::SECTOR_W-1:0]    fat_sector_i,
  // result word channel
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [fcsg_pkg::WORD_W-1:0]      entries_word_o,
  output      logic [fcsg_pkg::WORD_IDX_W-1:0]  word_index_o,
  output      logic                             last_word_o,
  output      logic                             range_error_o
);

  import fcsg_pkg::*;

  localparam int unsigned SlotCntW = $clog2(FILE_SLOTS + 1);
  localparam int unsigned SlotIdxW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int unsigned SlotSelW = $clog2(MAX_FILE_SLOTS);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_SEEK = 2'd2;
  localparam logic [1:0] ST_GEN  = 2'd3;

  // configuration registers
  logic [SECTOR_W-1:0]   spf_q;
  logic [CFG_DATA_W-1:0] files_q [SLOTS_PER_REG];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spf_q      <= SPF_RESET;
      files_q[0] <= FILES_0_3_RESET;
      files_q[1] <= FILES_4_7_RESET;
      files_q[2] <= FILES_8_11_RESET;
      files_q[3] <= FILES_12_15_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SECTORS_PER_FAT: spf_q      <= cfg_data_i[SECTOR_W-1:0];
        REG_FILES_0_3:       files_q[0] <= cfg_data_i;
        REG_FILES_4_7:       files_q[1] <= cfg_data_i;
        REG_FILES_8_11:      files_q[2] <= cfg_data_i;
        REG_FILES_12_15:     files_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and work registers
  logic [1:0]              state_q, state_d;
  logic [SECTOR_W-1:0]     idx_q, idx_d;
  logic                    err_q, err_d;
  logic [SlotIdxW-1:0]     f_q, f_d;
  logic [SlotCntW-1:0]     cnt_q, cnt_d;
  logic [SlotCntW-1:0]     p_q, p_d;
  logic [CLUSTER_W-1:0]    acc_q, acc_d;
  logic [ENTRY_IDX_W-1:0]  e_q, e_d;
  logic [3*ENTRY_W-1:0]    word_q, word_d;
  logic [CLUSTER_W-1:0]    ends_q [FILE_SLOTS];

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [WORD_W-1:0]       out_word_q, out_word_d;
  logic [WORD_IDX_W-1:0]   out_index_q, out_index_d;
  logic                    out_last_q, out_last_d;
  logic                    out_err_q, out_err_d;

  // request decode: fold the second copy onto the first
  logic                    in_accept;
  logic                    sec_in_first;
  logic                    sec_in_second;
  logic [SECTOR_W-1:0]     sec_folded;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign sec_in_first  = (fat_sector_i < spf_q);
  assign sec_in_second = ({1'b0, fat_sector_i} < {spf_q, 1'b0});
  assign sec_folded    = sec_in_first ? fat_sector_i : (fat_sector_i - spf_q);

  // cluster count of the current file slot
  logic [SlotSelW-1:0]   slot_sel;
  logic [ENTRY_W-1:0]    slot_len;
  logic [CLUSTER_W-1:0]  slot_end;

  assign slot_sel = SlotSelW'(f_q);
  assign slot_len = files_q[slot_sel[SlotSelW-1:2]][slot_sel[1:0]*ENTRY_W +: ENTRY_W];
  assign slot_end = acc_q + CLUSTER_W'(slot_len);

  // shared end-of-file compare: next file end vs current cluster (seek) or next cluster (gen)
  logic [CLUSTER_W-1:0]  cur_cluster;
  logic [CLUSTER_W-1:0]  cmp_operand;
  logic                  files_left;
  logic                  end_hit;

  assign cur_cluster = CLUSTER_W'({idx_q, e_q});
  assign cmp_operand = (state_q == ST_SEEK) ? cur_cluster : (cur_cluster + CLUSTER_W'(1));
  assign files_left  = (p_q != cnt_q);
  assign end_hit     = files_left && (ends_q[p_q[SlotIdxW-1:0]] <= cmp_operand);

  // entry value of the current cluster
  entry_t entry;

  always_comb begin
    priority if (err_q) begin
      entry = FREE_ENTRY;
    end else if (idx_q == '0 && e_q == ENTRY_IDX_W'(0)) begin
      entry = MEDIA_ENTRY;
    end else if (idx_q == '0 && e_q == ENTRY_IDX_W'(1)) begin
      entry = END_OF_CHAIN;
    end else if (!files_left) begin
      entry = FREE_ENTRY;
    end else if (end_hit) begin
      entry = END_OF_CHAIN;
    end else begin
      entry = cmp_operand[ENTRY_W-1:0];
    end
  end

  // generation step: a word's last entry waits for a free output register
  logic out_free;
  logic word_done;
  logic gen_step;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign word_done = (e_q[1:0] == 2'b11);
  assign gen_step  = (state_q == ST_GEN) && (!word_done || out_free);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    err_d       = err_q;
    f_d         = f_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    acc_d       = acc_q;
    e_d         = e_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    out_index_d = out_index_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d   = sec_in_first ? sec_folded : (sec_in_second ? sec_folded : '0);
          err_d   = !sec_in_first && !sec_in_second;
          f_d     = '0;
          cnt_d   = '0;
          p_d     = '0;
          acc_d   = FILE_AREA_BASE;
          e_d     = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        // running sum of cluster counts, nonempty file ends kept in order
        acc_d = slot_end;
        if (slot_len != '0) begin
          cnt_d = cnt_q + SlotCntW'(1);
        end
        if (f_q == SlotIdxW'(FILE_SLOTS - 1)) begin
          state_d = ST_SEEK;
        end else begin
          f_d = f_q + SlotIdxW'(1);
        end
      end
      ST_SEEK: begin
        // skip file ends at or below the sector's first cluster
        if (end_hit) begin
          p_d = p_q + SlotCntW'(1);
        end else begin
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        if (gen_step) begin
          if (files_left && end_hit) begin
            p_d = p_q + SlotCntW'(1);
          end
          e_d    = e_q + ENTRY_IDX_W'(1);
          word_d = {entry, word_q[3*ENTRY_W-1:ENTRY_W]};
          if (word_done) begin
            out_valid_d = 1'b1;
            out_word_d  = {entry, word_q};
            out_index_d = e_q[ENTRY_IDX_W-1:2];
            out_last_d  = (e_q == '1);
            out_err_d   = err_q;
            if (e_q == '1) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      f_q         <= '0;
      cnt_q       <= '0;
      p_q         <= '0;
      e_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      f_q         <= f_d;
      cnt_q       <= cnt_d;
      p_q         <= p_d;
      e_q         <= e_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    err_q       <= err_d;
    acc_q       <= acc_d;
    word_q      <= word_d;
    out_word_q  <= out_word_d;
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
    out_err_q   <= out_err_d;
  end

  // file end list, appended during the sum pass
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM && slot_len != '0) begin
      ends_q[cnt_q[SlotIdxW-1:0]] <= slot_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign entries_word_o = out_word_q;
  assign word_index_o   = out_index_q;
  assign last_word_o    = out_last_q;
  assign range_error_o  = out_err_q;

  // checks
  `FCSG_ASSERT(a_ptr_in_list, clk_i, rst_ni, p_q <= cnt_q, "file pointer beyond end list")
  `FCSG_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= SlotCntW'(FILE_SLOTS), "end list overflow")
  `FCSG_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && range_error_o, entries_word_o == '0, "range error word not zero")
  `FCSG_ASSERT_IMPL(a_last_idx, clk_i, rst_ni, out_valid_o && last_word_o, word_index_o == '1, "last word at wrong index")

endmodule

`default_nettype wire
